>>> hdl/pseudo_bayes_conditional_prob_top_macros.svh
// assertion macros used by the checker file
`ifndef PSEUDO_BAYES_CONDITIONAL_PROB_TOP_MACROS_SVH
`define PSEUDO_BAYES_CONDITIONAL_PROB_TOP_MACROS_SVH

// same-cycle implication, checked while out of reset
`define PBCP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked while out of reset
`define PBCP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/pbcp_pkg.sv
// ============================================================================
// pbcp_pkg
// Shared constants for the pseudo-Bayes conditional probability block.
// ============================================================================
package pbcp_pkg;

    // default count width and probability fraction width
    localparam int COUNT_BITS_DEF = 24;
    localparam int PROB_BITS_DEF  = 16;

    // fraction bits of the smoothing weight
    localparam int K_FRAC_BITS = 8;

endpackage

>>> hdl/pbcp_isqrt.sv
// ============================================================================
// pbcp_isqrt
// Pipelined integer square root, one result bit per stage, with a sideband
// word that travels alongside each transaction.
// ============================================================================
module pbcp_isqrt
    import pbcp_pkg::*;
#(
    parameter int IN_W   = COUNT_BITS_DEF + 2 * K_FRAC_BITS,
    parameter int RT_W   = (IN_W + 1) / 2,
    parameter int SIDE_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [IN_W-1:0]   in_data,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [RT_W-1:0]   out_root,
    output logic [SIDE_W-1:0] out_side
);

    localparam int RAD_W = 2 * RT_W;
    localparam int REM_W = RT_W + 2;

    logic              vld_reg  [RT_W];
    logic [RAD_W-1:0]  rad_reg  [RT_W];
    logic [REM_W-1:0]  rem_reg  [RT_W];
    logic [RT_W-1:0]   root_reg [RT_W];
    logic [SIDE_W-1:0] side_reg [RT_W];

    genvar k;
    generate
        for (k = 0; k < RT_W; k++) begin : g_stage
            logic              vld_prev;
            logic [RAD_W-1:0]  rad_prev;
            logic [REM_W-1:0]  rem_prev;
            logic [RT_W-1:0]   root_prev;
            logic [SIDE_W-1:0] side_prev;
            logic [REM_W-1:0]  rem_sh;
            logic [REM_W-1:0]  trial;
            logic              take;
            logic [REM_W-1:0]  rem_next;
            logic [RT_W-1:0]   root_next;

            // stage input select
            if (k == 0) begin : g_first
                assign vld_prev  = in_valid;
                assign rad_prev  = RAD_W'(in_data);
                assign rem_prev  = '0;
                assign root_prev = '0;
                assign side_prev = in_side;
            end else begin : g_rest
                assign vld_prev  = vld_reg[k-1];
                assign rad_prev  = rad_reg[k-1];
                assign rem_prev  = rem_reg[k-1];
                assign root_prev = root_reg[k-1];
                assign side_prev = side_reg[k-1];
            end

            // one digit of the root: bring down two bits, try (4r+1)
            always_comb begin
                rem_sh    = {rem_prev[RT_W-1:0], rad_prev[RAD_W-1 -: 2]};
                trial     = {root_prev, 2'b01};
                take      = (rem_sh >= trial);
                rem_next  = take ? (rem_sh - trial) : rem_sh;
                root_next = {root_prev[RT_W-2:0], take};
            end

            // stage registers
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[k] <= 1'b0;
                end else if (en) begin
                    vld_reg[k] <= vld_prev;
                end
                if (en) begin
                    rad_reg[k]  <= rad_prev << 2;
                    rem_reg[k]  <= rem_next;
                    root_reg[k] <= root_next;
                    side_reg[k] <= side_prev;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[RT_W-1];
    assign out_root  = root_reg[RT_W-1];
    assign out_side  = side_reg[RT_W-1];

endmodule

>>> hdl/pbcp_div.sv
// ============================================================================
// pbcp_div
// Pipelined fractional divider: a compare stage that flags a quotient of one
// or more, then one restoring step per quotient bit.
// ============================================================================
module pbcp_div
    import pbcp_pkg::*;
#(
    parameter int W      = 2 * COUNT_BITS_DEF + 9,
    parameter int Q_W    = PROB_BITS_DEF,
    parameter int SIDE_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [W-1:0]      in_num,
    input  logic [W-1:0]      in_den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [Q_W-1:0]    out_quot,
    output logic              out_sat,
    output logic [SIDE_W-1:0] out_side
);

    // compare stage
    logic              cmp_vld_reg;
    logic [W-1:0]      cmp_num_reg;
    logic [W-1:0]      cmp_den_reg;
    logic              cmp_sat_reg;
    logic [SIDE_W-1:0] cmp_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmp_vld_reg <= 1'b0;
        end else if (en) begin
            cmp_vld_reg <= in_valid;
        end
        if (en) begin
            cmp_num_reg  <= in_num;
            cmp_den_reg  <= in_den;
            cmp_sat_reg  <= (in_num >= in_den);
            cmp_side_reg <= in_side;
        end
    end

    logic              vld_reg  [Q_W];
    logic [W-1:0]      num_reg  [Q_W];
    logic [W-1:0]      den_reg  [Q_W];
    logic [Q_W-1:0]    quot_reg [Q_W];
    logic              sat_reg  [Q_W];
    logic [SIDE_W-1:0] side_reg [Q_W];

    genvar k;
    generate
        for (k = 0; k < Q_W; k++) begin : g_step
            logic              vld_prev;
            logic [W-1:0]      num_prev;
            logic [W-1:0]      den_prev;
            logic [Q_W-1:0]    quot_prev;
            logic              sat_prev;
            logic [SIDE_W-1:0] side_prev;
            logic [W:0]        num_sh;
            logic              take;
            logic [W:0]        num_next;

            // stage input select
            if (k == 0) begin : g_first
                assign vld_prev  = cmp_vld_reg;
                assign num_prev  = cmp_num_reg;
                assign den_prev  = cmp_den_reg;
                assign quot_prev = '0;
                assign sat_prev  = cmp_sat_reg;
                assign side_prev = cmp_side_reg;
            end else begin : g_rest
                assign vld_prev  = vld_reg[k-1];
                assign num_prev  = num_reg[k-1];
                assign den_prev  = den_reg[k-1];
                assign quot_prev = quot_reg[k-1];
                assign sat_prev  = sat_reg[k-1];
                assign side_prev = side_reg[k-1];
            end

            // shift, compare and subtract
            always_comb begin
                num_sh   = {num_prev, 1'b0};
                take     = (num_sh >= {1'b0, den_prev});
                num_next = take ? (num_sh - {1'b0, den_prev}) : num_sh;
            end

            // stage registers
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[k] <= 1'b0;
                end else if (en) begin
                    vld_reg[k] <= vld_prev;
                end
                if (en) begin
                    num_reg[k]  <= num_next[W-1:0];
                    den_reg[k]  <= den_prev;
                    quot_reg[k] <= {quot_prev[Q_W-2:0], take};
                    sat_reg[k]  <= sat_prev;
                    side_reg[k] <= side_prev;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[Q_W-1];
    assign out_quot  = quot_reg[Q_W-1];
    assign out_sat   = sat_reg[Q_W-1];
    assign out_side  = side_reg[Q_W-1];

endmodule

>>> hdl/pseudo_bayes_conditional_prob_top.sv
// Smoothed conditional probability p(a|b), or p(!a|!b) with negate set, from
// co-occurrence counts and the scene count N held in the scene_cnt_reg register.
// The block is a fully pipelined datapath: one transaction is accepted every
// cycle while s_ready is high, and each result passes through (COUNT_BITS + 17)/2 +
// PROB_BITS + 6 register stages (42 at the default widths), set mostly by the
// one-bit-per-stage square root and divider. The whole pipeline advances
// together; s_ready drops only while a finished result waits in the output
// register and m_ready is low. Inconsistent counts give count_error = 1 and
// probability 0. Write the scene count only while no transaction is in flight.
// ============================================================================
// pseudo_bayes_conditional_prob_top
// Pseudo-Bayes minimax smoothed conditional probability, pipelined.
// ============================================================================
module pseudo_bayes_conditional_prob_top
    import pbcp_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int PROB_BITS  = PROB_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration
    input  logic                  cfg_wr_en,
    input  logic [COUNT_BITS-1:0] cfg_wr_data,
    // input channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [COUNT_BITS-1:0] s_count_a,
    input  logic [COUNT_BITS-1:0] s_count_b,
    input  logic [COUNT_BITS-1:0] s_count_ab,
    input  logic                  s_negate,
    // result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [PROB_BITS-1:0]  m_probability,
    output logic                  m_count_error
);

    localparam int CB     = COUNT_BITS;
    localparam int SQ_IN  = CB + 2 * K_FRAC_BITS;
    localparam int RW     = (SQ_IN + 1) / 2;
    localparam int DFW    = CB + K_FRAC_BITS + 1;
    localparam int DW     = 2 * CB + K_FRAC_BITS + 1;
    localparam int SIDE_W = 1 + 4 * CB;
    localparam logic [RW-1:0] K_MIN = RW'(1 << K_FRAC_BITS);

    logic en;

    // configuration register
    logic [CB-1:0] scene_cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scene_cnt_reg <= CB'(1);
        end else if (cfg_wr_en) begin
            scene_cnt_reg <= cfg_wr_data;
        end
    end

    // whole pipeline moves unless the output register is held
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // input capture stage
    logic          in_vld_reg;
    logic [CB-1:0] na_reg, nb_reg, nab_reg;
    logic          neg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (en) begin
            in_vld_reg <= s_valid;
        end
        if (en) begin
            na_reg  <= s_count_a;
            nb_reg  <= s_count_b;
            nab_reg <= s_count_ab;
            neg_reg <= s_negate;
        end
    end

    // consistency check and operand selection
    logic          err_c;
    logic [CB-1:0] nobs_c, x_c, ma_c;

    always_comb begin
        err_c = (scene_cnt_reg == '0) || (na_reg > scene_cnt_reg) ||
                (nb_reg > scene_cnt_reg) || (nab_reg > na_reg) ||
                (nab_reg > nb_reg) ||
                ((na_reg - nab_reg) > (scene_cnt_reg - nb_reg));
        nobs_c = neg_reg ? (scene_cnt_reg - nb_reg) : nb_reg;
        x_c    = neg_reg ? ((scene_cnt_reg - nb_reg) - (na_reg - nab_reg)) : nab_reg;
        ma_c   = neg_reg ? (scene_cnt_reg - na_reg) : na_reg;
    end

    logic              prep_vld_reg;
    logic [SIDE_W-1:0] prep_side_reg;
    logic [CB-1:0]     prep_nobs_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prep_vld_reg <= 1'b0;
        end else if (en) begin
            prep_vld_reg <= in_vld_reg;
        end
        if (en) begin
            prep_side_reg <= {err_c, scene_cnt_reg, nobs_c, x_c, ma_c};
            prep_nobs_reg <= nobs_c;
        end
    end

    // square root of NObs in Q.16 gives K in Q.8
    logic              sq_vld;
    logic [RW-1:0]     sq_root;
    logic [SIDE_W-1:0] sq_side;

    pbcp_isqrt #(
        .IN_W   (SQ_IN),
        .RT_W   (RW),
        .SIDE_W (SIDE_W)
    ) u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (prep_vld_reg),
        .in_data   ({prep_nobs_reg, {(2 * K_FRAC_BITS){1'b0}}}),
        .in_side   (prep_side_reg),
        .out_valid (sq_vld),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    // unpack sideband and floor K at one
    logic          sq_err;
    logic [CB-1:0] sq_n, sq_nobs, sq_x, sq_ma;
    logic [RW-1:0] kq;

    assign {sq_err, sq_n, sq_nobs, sq_x, sq_ma} = sq_side;
    assign kq = (sq_root < K_MIN) ? K_MIN : sq_root;

    // products stage
    logic             mul_vld_reg;
    logic             mul_err_reg;
    logic [2*CB-1:0]  p_nx_reg;
    logic [CB+RW-1:0] p_km_reg;
    logic [DW-1:0]    den_reg;
    logic [DFW-1:0]   den_f;

    assign den_f = DFW'({sq_nobs, {K_FRAC_BITS{1'b0}}}) + DFW'(kq);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_vld_reg <= 1'b0;
        end else if (en) begin
            mul_vld_reg <= sq_vld;
        end
        if (en) begin
            mul_err_reg <= sq_err;
            p_nx_reg    <= (2*CB)'(sq_n) * (2*CB)'(sq_x);
            p_km_reg    <= (CB+RW)'(kq) * (CB+RW)'(sq_ma);
            den_reg     <= DW'(sq_n) * DW'(den_f);
        end
    end

    // numerator sum stage
    logic          sum_vld_reg;
    logic          sum_err_reg;
    logic [DW-1:0] num_reg;
    logic [DW-1:0] den2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_vld_reg <= 1'b0;
        end else if (en) begin
            sum_vld_reg <= mul_vld_reg;
        end
        if (en) begin
            sum_err_reg <= mul_err_reg;
            num_reg     <= DW'({p_nx_reg, {K_FRAC_BITS{1'b0}}}) + DW'(p_km_reg);
            den2_reg    <= den_reg;
        end
    end

    // divide
    logic                 dv_vld;
    logic [PROB_BITS-1:0] dv_quot;
    logic                 dv_sat;
    logic                 dv_err;

    pbcp_div #(
        .W      (DW),
        .Q_W    (PROB_BITS),
        .SIDE_W (1)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sum_vld_reg),
        .in_num    (num_reg),
        .in_den    (den2_reg),
        .in_side   (sum_err_reg),
        .out_valid (dv_vld),
        .out_quot  (dv_quot),
        .out_sat   (dv_sat),
        .out_side  (dv_err)
    );

    // output register
    logic                 out_vld_reg;
    logic [PROB_BITS-1:0] prob_reg;
    logic                 err_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en) begin
            out_vld_reg <= dv_vld;
        end
        if (en) begin
            err_reg  <= dv_err;
            prob_reg <= dv_err ? '0 : (dv_sat ? {PROB_BITS{1'b1}} : dv_quot);
        end
    end

    assign m_valid       = out_vld_reg;
    assign m_probability = prob_reg;
    assign m_count_error = err_reg;

endmodule

>>> hdl/pbcp_checker.sv
// ============================================================================
// pbcp_checker
// Port-level checks on the conditional probability block, bound to the top.
// ============================================================================
`include "pseudo_bayes_conditional_prob_top_macros.svh"

module pbcp_checker
    import pbcp_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int PROB_BITS  = PROB_BITS_DEF
) (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [PROB_BITS-1:0]  m_probability,
    input logic                  m_count_error
);

    // a held result keeps its value
    `PBCP_ASSERT_NEXT(a_hold, m_valid && !m_ready, m_valid && $stable(m_probability) && $stable(m_count_error), "result changed while stalled")

    // inconsistent counts always report a zero probability
    `PBCP_ASSERT_NOW(a_err_zero, m_valid && m_count_error, m_probability == '0, "error result with nonzero probability")

    // the input side never stalls while the output side drains
    `PBCP_ASSERT_NOW(a_flow, m_ready, s_ready, "input stalled while output ready")

    // with no result waiting the block takes a transaction
    `PBCP_ASSERT_NOW(a_empty_ready, !m_valid, s_ready, "input stalled with empty output")

endmodule

bind pseudo_bayes_conditional_prob_top pbcp_checker #(
    .COUNT_BITS (COUNT_BITS),
    .PROB_BITS  (PROB_BITS)
) u_pbcp_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_probability (m_probability),
    .m_count_error (m_count_error)
);
